[rtl/kpdc_pkg.sv]
// kpdc_pkg: shared constants and types for the key press duration classifier
// no dependencies; used by kpdc_press_if, the top level and the test bench

package kpdc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned OUT_HOLD_W      = 16;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [1:0]            press_class_t;

  // register indexes
  localparam cfg_addr_t REG_DEBOUNCE_TICKS   = 3'd0;
  localparam cfg_addr_t REG_LONG_THRESHOLD   = 3'd1;
  localparam cfg_addr_t REG_VERY_LONG_THRESH = 3'd2;
  localparam cfg_addr_t REG_SHORT_ENABLE     = 3'd3;
  localparam cfg_addr_t REG_LONG_ENABLE      = 3'd4;
  localparam cfg_addr_t REG_VERY_LONG_ENABLE = 3'd5;

  // reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_DEF  = 16'd50;
  localparam logic [CFG_W-1:0] LONG_DEF      = 16'd40;
  localparam logic [CFG_W-1:0] VERY_LONG_DEF = 16'd200;

  // press classes
  localparam press_class_t CLASS_SHORT     = 2'd0;
  localparam press_class_t CLASS_LONG      = 2'd1;
  localparam press_class_t CLASS_VERY_LONG = 2'd2;

endpackage

[rtl/kpdc_key_if.sv]
// kpdc_key_if: valid/ready channel carrying one sampled key level per tick
// depends on nothing

interface kpdc_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

[rtl/kpdc_press_if.sv]
// kpdc_press_if: valid/ready channel carrying one classified key press
// depends on kpdc_pkg for the class type and report width

interface kpdc_press_if;
  logic                                    valid;
  logic                                    ready;
  kpdc_pkg::press_class_t                  press_class;
  logic [kpdc_pkg::OUT_HOLD_W-1:0]         hold_periods;

  modport source (output valid, output press_class, output hold_periods, input ready);
  modport sink (input valid, input press_class, input hold_periods, output ready);
endinterface

[rtl/key_press_duration_classifier.sv]
// key_press_duration_classifier: debounced key press timing and classification
// depends on kpdc_pkg, kpdc_key_if and kpdc_press_if
// a press report is registered: it appears in the cycle after the tick that ends the press
// throughput: one key tick per cycle; the single result register holds a report
// until it is taken, and a tick is taken only when that register is free or draining
// reset (rst, synchronous): registers to defaults, key idle, timer stopped, no report

module key_press_duration_classifier #(
  parameter int unsigned COUNT_WIDTH = kpdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  kpdc_pkg::cfg_addr_t            cfg_addr,
  input  logic [kpdc_pkg::CFG_W-1:0]     cfg_wdata,
  kpdc_key_if.sink                       key,
  kpdc_press_if.source                   press
);
  import kpdc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_DOWN     = 2'd2;
  localparam logic [1:0] PH_RELEASED = 2'd3;

  localparam logic [1:0] EM_FALLING = 2'd0;
  localparam logic [1:0] EM_RISING  = 2'd1;
  localparam logic [1:0] EM_ANY     = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] HOLD_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CMP_W-1:0]       REPORT_MAX = CMP_W'({OUT_HOLD_W{1'b1}});

  // configuration
  logic [CFG_W-1:0] debounce_ticks;
  logic [CFG_W-1:0] long_threshold;
  logic [CFG_W-1:0] very_long_threshold;
  logic             short_enable;
  logic             long_enable;
  logic             very_long_enable;

  // key state
  logic [1:0]             phase, phase_next;
  logic [1:0]             edge_mode, edge_mode_next;
  logic                   last_level;
  logic [CFG_W-1:0]       countdown, countdown_next;
  logic [COUNT_WIDTH-1:0] hold_count, hold_count_next;

  // result register
  logic                  out_valid;
  press_class_t          out_class;
  logic [OUT_HOLD_W-1:0] out_hold;

  logic                  accept;
  logic                  lvl, falling, rising, edge_en;
  logic [CFG_W-1:0]      period, cd_dec;
  logic [CMP_W-1:0]      hold_ext;
  logic                  is_very_long, is_long;
  logic                  emit;
  press_class_t          emit_class;
  logic [OUT_HOLD_W-1:0] emit_hold;

  assign key.ready = !out_valid || press.ready;
  assign accept    = key.valid && key.ready;
  assign lvl       = key.key_level;

  assign falling = last_level && !lvl;
  assign rising  = !last_level && lvl;
  assign edge_en = ((edge_mode == EM_ANY) && (falling || rising)) ||
                   ((edge_mode == EM_FALLING) && falling) ||
                   ((edge_mode == EM_RISING) && rising);

  // zero period behaves as one tick
  assign period = (debounce_ticks == '0) ? CFG_W'(1) : debounce_ticks;
  assign cd_dec = countdown - CFG_W'(1);

  assign hold_ext     = CMP_W'(hold_count);
  assign is_very_long = very_long_enable && (hold_ext > CMP_W'(very_long_threshold));
  assign is_long      = long_enable && (hold_ext > CMP_W'(long_threshold));
  assign emit_hold    = (hold_ext > REPORT_MAX) ? {OUT_HOLD_W{1'b1}}
                                                : hold_ext[OUT_HOLD_W-1:0];

  always_comb begin
    phase_next      = phase;
    edge_mode_next  = edge_mode;
    countdown_next  = countdown;
    hold_count_next = hold_count;
    emit            = 1'b0;
    emit_class      = CLASS_SHORT;
    if (edge_en) begin
      case (phase)
        PH_IDLE: phase_next = PH_PRESSED;
        PH_DOWN: phase_next = PH_RELEASED;
        default: phase_next = phase;
      endcase
      countdown_next = period;
      edge_mode_next = EM_ANY;
    end else if (countdown != '0) begin
      countdown_next = cd_dec;
      if (cd_dec == '0) begin
        if (lvl) begin
          // released: classify and report (short presses only if enabled)
          phase_next      = PH_IDLE;
          edge_mode_next  = EM_FALLING;
          hold_count_next = '0;
          if (is_very_long) begin
            emit       = 1'b1;
            emit_class = CLASS_VERY_LONG;
          end else if (is_long) begin
            emit       = 1'b1;
            emit_class = CLASS_LONG;
          end else begin
            emit       = short_enable;
          end
        end else begin
          // still held: one more period
          phase_next      = PH_DOWN;
          edge_mode_next  = EM_RISING;
          countdown_next  = period;
          if (hold_count != HOLD_MAX) begin
            hold_count_next = hold_count + COUNT_WIDTH'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks      <= DEBOUNCE_DEF;
      long_threshold      <= LONG_DEF;
      very_long_threshold <= VERY_LONG_DEF;
      short_enable        <= 1'b1;
      long_enable         <= 1'b1;
      very_long_enable    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE_TICKS:   debounce_ticks      <= cfg_wdata;
        REG_LONG_THRESHOLD:   long_threshold      <= cfg_wdata;
        REG_VERY_LONG_THRESH: very_long_threshold <= cfg_wdata;
        REG_SHORT_ENABLE:     short_enable        <= cfg_wdata[0];
        REG_LONG_ENABLE:      long_enable         <= cfg_wdata[0];
        REG_VERY_LONG_ENABLE: very_long_enable    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      edge_mode  <= EM_FALLING;
      last_level <= 1'b1;
      countdown  <= '0;
      hold_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      edge_mode  <= edge_mode_next;
      last_level <= lvl;
      countdown  <= countdown_next;
      hold_count <= hold_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (press.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_class <= emit_class;
      out_hold  <= emit_hold;
    end
  end

  assign press.valid        = out_valid;
  assign press.press_class  = out_class;
  assign press.hold_periods = out_hold;

  // a running timer always belongs to a press in progress
  a_timer_not_idle: assert property (@(posedge clk) disable iff (rst)
    (countdown != '0) |-> (phase != PH_IDLE))
    else $error("debounce timer running while idle");

  // idle means only falling edges are armed and nothing is counted
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> ((edge_mode == EM_FALLING) && (hold_count == '0)))
    else $error("idle phase with stale edge mode or hold count");

  // a report only ends a pressed or released phase
  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |-> ((phase == PH_PRESSED) || (phase == PH_RELEASED)))
    else $error("press report from unexpected phase");

  // an accepted edge reloads the timer with the debounce period
  a_timer_bound: assert property (@(posedge clk) disable iff (rst)
    (accept && edge_en) |=> (countdown == $past(period)))
    else $error("timer not reloaded with the debounce period");

  // a waiting report is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !press.ready) |-> !accept)
    else $error("key tick taken while report stalled");

endmodule

[verif/key_press_duration_classifier_test.sv]
// key_press_duration_classifier_test: self-checking bench for the key press classifier
// depends on kpdc_pkg, kpdc_key_if, kpdc_press_if and key_press_duration_classifier
// drives key ticks under random flow control and checks every press report in order

module key_press_duration_classifier_test;
  import kpdc_pkg::*;

  localparam int unsigned HOLD_W         = COUNT_WIDTH_DEF;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned RANDOM_TICKS   = 64;
  localparam logic [OUT_HOLD_W-1:0] HOLD_OUT_MAX = '1;

  // indexes that decode to no register
  localparam cfg_addr_t REG_SPARE_LO = 3'd6;
  localparam cfg_addr_t REG_SPARE_HI = 3'd7;

  class press_scoreboard;
    typedef enum logic [1:0] {PH_IDLE, PH_PRESSED, PH_DOWN, PH_RELEASED} phase_t;
    typedef enum logic [1:0] {EDGE_FALLING, EDGE_RISING, EDGE_ANY} edge_mode_t;
    typedef struct packed {
      press_class_t            press_class;
      logic [OUT_HOLD_W-1:0]   hold_periods;
    } press_t;

    logic [CFG_W-1:0]  debounce_ticks;
    logic [CFG_W-1:0]  long_threshold;
    logic [CFG_W-1:0]  very_long_threshold;
    bit                short_en;
    bit                long_en;
    bit                very_long_en;

    phase_t            phase;
    edge_mode_t        edge_mode;
    bit                last_level;
    logic [CFG_W-1:0]  countdown;
    logic [HOLD_W-1:0] hold_count;

    press_t            expected[$];
    int unsigned       mismatches;

    function new();
      debounce_ticks      = DEBOUNCE_DEF;
      long_threshold      = LONG_DEF;
      very_long_threshold = VERY_LONG_DEF;
      short_en            = 1'b1;
      long_en             = 1'b1;
      very_long_en        = 1'b1;
      phase               = PH_IDLE;
      edge_mode           = EDGE_FALLING;
      last_level          = 1'b1;
      countdown           = '0;
      hold_count          = '0;
      mismatches          = 0;
    endfunction

    function void set_register(cfg_addr_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_DEBOUNCE_TICKS:   debounce_ticks      = value;
        REG_LONG_THRESHOLD:   long_threshold      = value;
        REG_VERY_LONG_THRESH: very_long_threshold = value;
        REG_SHORT_ENABLE:     short_en            = value[0];
        REG_LONG_ENABLE:      long_en             = value[0];
        REG_VERY_LONG_ENABLE: very_long_en        = value[0];
        default: ;
      endcase
    endfunction

    // one accepted key tick; queues the press report it causes, if any
    function void note_tick(bit level);
      bit               fell;
      bit               rose;
      bit               armed;
      bit               emit;
      logic [CFG_W-1:0] period;
      press_t           rpt;
      fell  = last_level && !level;
      rose  = !last_level && level;
      armed = (edge_mode == EDGE_ANY && (fell || rose)) ||
              (edge_mode == EDGE_FALLING && fell) ||
              (edge_mode == EDGE_RISING && rose);
      last_level = level;
      period = (debounce_ticks == '0) ? CFG_W'(1) : debounce_ticks;
      // an edge restarts the timer and skips this tick's decrement
      if (armed) begin
        if (phase == PH_IDLE) phase = PH_PRESSED;
        else if (phase == PH_DOWN) phase = PH_RELEASED;
        countdown = period;
        edge_mode = EDGE_ANY;
        return;
      end
      if (countdown == '0) return;
      countdown = countdown - 1'b1;
      if (countdown != '0) return;
      if (level) begin
        phase     = PH_IDLE;
        edge_mode = EDGE_FALLING;
        emit      = 1'b1;
        if (very_long_en && hold_count > very_long_threshold) begin
          rpt.press_class = CLASS_VERY_LONG;
        end else if (long_en && hold_count > long_threshold) begin
          rpt.press_class = CLASS_LONG;
        end else begin
          rpt.press_class = CLASS_SHORT;
          emit            = short_en;
        end
        rpt.hold_periods = (hold_count > HOLD_OUT_MAX) ? HOLD_OUT_MAX : OUT_HOLD_W'(hold_count);
        if (emit) expected.push_back(rpt);
        hold_count = '0;
      end else begin
        phase = PH_DOWN;
        if (hold_count != '1) hold_count = hold_count + 1'b1;
        countdown = period;
        edge_mode = EDGE_RISING;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_press(press_class_t cls, logic [OUT_HOLD_W-1:0] hold);
      press_t want;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("unexpected press, class %0d hold %0d", cls, hold));
        return;
      end
      want = expected.pop_front();
      if (cls !== want.press_class)
        report_mismatch($sformatf("press_class %0d, wanted %0d", cls, want.press_class));
      if (hold !== want.hold_periods)
        report_mismatch($sformatf("hold_periods %0d, wanted %0d", hold, want.hold_periods));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  cfg_addr_t        cfg_addr  = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  kpdc_key_if   key_ch();
  kpdc_press_if press_ch();

  press_scoreboard sb;

  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned stall_req_count = 0;
  int unsigned stall_len       = 0;
  int unsigned ticks_sent      = 0;

  key_press_duration_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .key       (key_ch),
    .press     (press_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb: failure");
    $finish;
  end

  // result side: random ready, with a long hold-off on request
  initial begin
    int unsigned seen;
    int unsigned left;
    seen = 0;
    left = 0;
    press_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req_count != seen) begin
        seen = stall_req_count;
        left = stall_len;
      end
      if (left > 0) begin
        left--;
        press_ch.ready <= 1'b0;
      end else begin
        press_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && press_ch.valid && press_ch.ready)
      sb.check_press(press_ch.press_class, press_ch.hold_periods);
  end

  task automatic pause_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk) key_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_tick(bit level);
    if ($urandom_range(0, 99) < send_idle_pct) pause_sender($urandom_range(1, 3));
    @(negedge clk);
    key_ch.valid     <= 1'b1;
    key_ch.key_level <= level;
    do @(posedge clk); while (!key_ch.ready);
    sb.note_tick(level);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    pause_sender(1);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_addr_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    sb.set_register(idx, value);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic load_settings(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng,
                               logic [CFG_W-1:0] vlng, bit se, bit le, bit vle);
    wait_drained();
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_LONG_THRESHOLD, lng);
    write_reg(REG_VERY_LONG_THRESH, vlng);
    write_reg(REG_SHORT_ENABLE, CFG_W'(se));
    write_reg(REG_LONG_ENABLE, CFG_W'(le));
    write_reg(REG_VERY_LONG_ENABLE, CFG_W'(vle));
  endtask

  // contact bounce before the held stretch and again before the released stretch
  task automatic key_press(int unsigned low_len, int unsigned high_len, int unsigned bounce);
    for (int i = 0; i < bounce; i++) send_tick(i[0]);
    repeat (low_len) send_tick(1'b0);
    for (int i = 0; i < bounce; i++) send_tick(!i[0]);
    repeat (high_len) send_tick(1'b1);
  endtask

  task automatic random_press(int unsigned period);
    int unsigned low_len;
    int unsigned high_len;
    int unsigned bounce;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
      return;
    end
    low_len  = $urandom_range(0, period * 14);
    // now and then a release too short to finish the press
    high_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, period)
                                           : $urandom_range(period + 1, period + 3);
    bounce   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    key_press(low_len, high_len, bounce);
  endtask

  task automatic random_round(int unsigned r);
    int unsigned      period;
    int unsigned      start;
    logic [CFG_W-1:0] deb;
    logic [CFG_W-1:0] lng;
    case (r)
      0: begin
        load_settings('0, '0, '0, 1'b1, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        period = 1;
      end
      1: begin
        load_settings(CFG_W'(1), '1, '1, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        period = 1;
      end
      default: begin
        deb = CFG_W'($urandom_range(2, 4));
        lng = CFG_W'($urandom_range(0, 6));
        load_settings(deb, lng, CFG_W'($urandom_range(lng, 12)), $urandom_range(0, 3) != 0,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        period = deb;
      end
    endcase
    start = ticks_sent;
    while (ticks_sent - start < RANDOM_TICKS) random_press(period);
  endtask

  initial begin
    sb = new();
    key_ch.valid     = 1'b0;
    key_ch.key_level = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_idle_pct = 10;
    recv_idle_pct = 66;

    // presses timed with the reset settings
    key_press(60, 55, 0);
    key_press($urandom_range(100, 150), 52, 1);

    // zero period behaves as one tick; spare indexes must be ignored
    load_settings('0, CFG_W'(1), CFG_W'(3), 1'b1, 1'b1, 1'b1);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, CFG_W'(1));
    key_press(5, 2, 0);
    // glitch: the rising edge lands on the expiring tick and restarts the timer
    key_press(1, 2, 0);
    key_press(3, 2, 0);
    load_settings(CFG_W'(2), CFG_W'(1), CFG_W'(3), 1'b1, 1'b1, 1'b1);
    key_press(3, 3, 0);
    // every class off: release clears the count with no report
    load_settings(CFG_W'(1), '0, '0, 1'b0, 1'b0, 1'b0);
    key_press(3, 2, 0);

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int r = 0; r < 3; r++) random_round(r);
    end

    // hold results back long enough for the report register to block key ticks
    load_settings(CFG_W'(1), CFG_W'(3), CFG_W'(8), 1'b1, 1'b1, 1'b1);
    stall_len = 300;
    stall_req_count++;
    repeat (20) key_press($urandom_range(0, 10), 2, 0);
    wait_drained();

    pause_sender(1);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
